// File: rtl/cbb_pkg.sv
// Shared types and constants for the clamped box blur block.
package cbb_pkg;

	localparam int MAX_WIDTH = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int MAX_CHANNELS = 4;

	localparam int NUM_CH = 4;
	localparam int SUM_W = 24;

	localparam logic [1:0] REG_WIDTH = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_CHANNELS = 2'd2;
	localparam logic [1:0] REG_RADIUS = 2'd3;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

	typedef struct packed {
		logic       cmd;
		logic [7:0] in_ch0;
		logic [7:0] in_ch1;
		logic [7:0] in_ch2;
		logic [7:0] in_ch3;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_ch0;
		logic [7:0] out_ch1;
		logic [7:0] out_ch2;
		logic [7:0] out_ch3;
		logic       frame_last;
		logic       fetch_status;
	} out_word_t;

	// Classified work between front and back.
	typedef enum logic [1:0] {
		OP_LOAD,
		OP_FETCH,
		OP_NOTREADY
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] v0;
		logic [7:0] v1;
		logic [7:0] v2;
		logic [7:0] v3;
		logic       last;
	} job_t;

endpackage

// File: rtl/cbb_front.sv
// Front end: accepts words, tracks load/fetch positions, classifies jobs.
module cbb_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              restart,
	input  logic [8:0]        eff_w,
	input  logic [8:0]        eff_h,
	input  cbb_pkg::in_word_t word,
	input  logic              take,
	output cbb_pkg::job_t     job
);

	logic [8:0] lcol_q, lrow_q, fcol_q, frow_q;
	logic       done_q;

	always_comb begin
		job.v0 = word.in_ch0;
		job.v1 = word.in_ch1;
		job.v2 = word.in_ch2;
		job.v3 = word.in_ch3;
		job.last = 1'b0;
		if (word.cmd == cbb_pkg::CMD_LOAD) begin
			job.op = cbb_pkg::OP_LOAD;
		end else if (!done_q) begin
			job.op = cbb_pkg::OP_NOTREADY;
		end else begin
			job.op = cbb_pkg::OP_FETCH;
			job.last = (fcol_q + 9'd1 >= eff_w) && (frow_q + 9'd1 >= eff_h);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcol_q <= '0; lrow_q <= '0; fcol_q <= '0; frow_q <= '0; done_q <= 1'b0;
		end else if (restart) begin
			lcol_q <= '0; lrow_q <= '0; fcol_q <= '0; frow_q <= '0; done_q <= 1'b0;
		end else if (take) begin
			if (job.op == cbb_pkg::OP_LOAD) begin
				if (done_q) begin
					fcol_q <= '0;
					frow_q <= '0;
				end
				if (lcol_q + 9'd1 >= eff_w || done_q) begin
					lcol_q <= (done_q && eff_w != 9'd1) ? 9'd1 : 9'd0;
				end else begin
					lcol_q <= lcol_q + 9'd1;
				end
				if (done_q) begin
					lrow_q <= (eff_w == 9'd1) ? 9'd1 : 9'd0;
					done_q <= (eff_w == 9'd1) && (eff_h == 9'd1);
				end else if (lcol_q + 9'd1 >= eff_w) begin
					lrow_q <= lrow_q + 9'd1;
					done_q <= (lrow_q + 9'd1 >= eff_h);
				end
			end else if (job.op == cbb_pkg::OP_FETCH) begin
				if (fcol_q + 9'd1 >= eff_w) begin
					fcol_q <= '0;
					frow_q <= (frow_q + 9'd1 >= eff_h) ? 9'd0 : frow_q + 9'd1;
				end else begin
					fcol_q <= fcol_q + 9'd1;
				end
			end
		end
	end

endmodule

// File: rtl/cbb_back.sv
// Back end: builds the summed-area table and computes window means.
module cbb_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               restart,
	input  logic [8:0]         eff_w,
	input  logic [8:0]         eff_h,
	input  logic [2:0]         eff_c,
	input  logic [7:0]         radius,
	input  logic               job_valid,
	input  cbb_pkg::job_t      job,
	output logic               job_take,
	output logic               res_valid,
	output cbb_pkg::out_word_t res,
	input  logic               res_take
);

	localparam int XW = $clog2(cbb_pkg::MAX_WIDTH);
	localparam int YW = $clog2(cbb_pkg::MAX_HEIGHT);
	localparam int CW = (cbb_pkg::MAX_CHANNELS > 1) ? $clog2(cbb_pkg::MAX_CHANNELS) : 1;
	localparam int AW = YW + XW + CW;
	localparam int DEPTH = cbb_pkg::MAX_WIDTH * cbb_pkg::MAX_HEIGHT * cbb_pkg::MAX_CHANNELS;
	localparam int DW = 8 + 2 * 9;

	typedef enum logic [3:0] {
		S_IDLE, S_LRD, S_LWR, S_FSET, S_FRD, S_FACC, S_DIV, S_DIVDONE, S_NEXT, S_OUT
	} state_t;

	logic [cbb_pkg::SUM_W-1:0] mem [DEPTH];
	logic [cbb_pkg::SUM_W-1:0] rd_q;
	logic                      we;
	logic [AW-1:0]             waddr, raddr;
	logic [cbb_pkg::SUM_W-1:0] wdata;

	state_t state_q;
	cbb_pkg::job_t job_q;
	logic [8:0] x_q, y_q, lx_q, ly_q, fx_q, fy_q;
	logic [8:0] x0_q, x1_q, y0_q, y1_q;
	logic [1:0] ch_q, corner_q;
	logic [cbb_pkg::SUM_W-1:0] run_q [cbb_pkg::NUM_CH];
	logic [cbb_pkg::SUM_W-1:0] acc_q;
	logic [17:0] count_q;
	logic [DW-1:0] rem_q;
	logic [cbb_pkg::SUM_W-1:0] quo_q;
	logic [4:0] bit_q;
	logic [7:0] outv_q [cbb_pkg::NUM_CH];
	logic last_q;
	logic rd_pend_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	function automatic logic [AW-1:0] addr_of(logic [8:0] r, logic [8:0] c, logic [1:0] ch);
		addr_of = {r[YW-1:0], c[XW-1:0], ch[CW-1:0]};
	endfunction

	logic [8:0] cr, cc;
	logic       cz;
	logic [8:0] yx, xx;
	always_comb begin
		case (corner_q)
			2'd0: begin cr = y1_q; cc = x1_q; end
			2'd1: begin cr = y0_q - 9'd1; cc = x1_q; end
			2'd2: begin cr = y1_q; cc = x0_q - 9'd1; end
			default: begin cr = y0_q - 9'd1; cc = x0_q - 9'd1; end
		endcase
		cz = ((corner_q[0]) && y0_q == 9'd0) || ((corner_q[1]) && x0_q == 9'd0);
		yx = 9'(y_q + {1'b0, radius});
		xx = 9'(x_q + {1'b0, radius});
	end

	logic [7:0] vin;
	always_comb begin
		case (ch_q)
			2'd0: vin = job_q.v0;
			2'd1: vin = job_q.v1;
			2'd2: vin = job_q.v2;
			default: vin = job_q.v3;
		endcase
	end

	logic [cbb_pkg::SUM_W-1:0] rsum;
	assign rsum = run_q[ch_q] + {16'd0, vin};

	always_comb begin
		we = (state_q == S_LWR);
		waddr = addr_of(ly_q, lx_q, ch_q);
		wdata = rsum + ((ly_q != 9'd0) ? rd_q : '0);
		raddr = (state_q == S_LRD) ? addr_of(ly_q - 9'd1, lx_q, ch_q) : addr_of(cr, cc, ch_q);
	end

	logic [DW-1:0] trial;
	assign trial = {rem_q[DW-2:0], acc_q[bit_q]};

	assign job_take = job_valid && (state_q == S_IDLE);
	assign res_valid = (state_q == S_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lx_q <= '0; ly_q <= '0; fx_q <= '0; fy_q <= '0;
			for (int i = 0; i < cbb_pkg::NUM_CH; i++) run_q[i] <= '0;
		end else if (restart) begin
			state_q <= S_IDLE;
			lx_q <= '0; ly_q <= '0; fx_q <= '0; fy_q <= '0;
			for (int i = 0; i < cbb_pkg::NUM_CH; i++) run_q[i] <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (job_take) begin
						job_q <= job;
						ch_q <= '0;
						last_q <= job.last;
						for (int i = 0; i < cbb_pkg::NUM_CH; i++) outv_q[i] <= '0;
						if (job.op == cbb_pkg::OP_LOAD) begin
							if (ly_q >= eff_h) begin
								ly_q <= '0; lx_q <= '0; fx_q <= '0; fy_q <= '0;
							end
							state_q <= S_LRD;
						end else if (job.op == cbb_pkg::OP_FETCH) begin
							x_q <= fx_q; y_q <= fy_q;
							state_q <= S_FSET;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_LRD: state_q <= S_LWR;
				S_LWR: begin
					if (3'(ch_q) + 3'd1 >= eff_c) begin
						ch_q <= '0;
						state_q <= S_IDLE;
						if (lx_q + 9'd1 >= eff_w) begin
							lx_q <= '0;
							ly_q <= ly_q + 9'd1;
							for (int i = 0; i < cbb_pkg::NUM_CH; i++) run_q[i] <= '0;
						end else begin
							lx_q <= lx_q + 9'd1;
							run_q[ch_q] <= rsum;
						end
					end else begin
						run_q[ch_q] <= rsum;
						ch_q <= ch_q + 2'd1;
						state_q <= S_LRD;
					end
				end
				S_FSET: begin
					y0_q <= (y_q > {1'b0, radius}) ? y_q - {1'b0, radius} : 9'd0;
					x0_q <= (x_q > {1'b0, radius}) ? x_q - {1'b0, radius} : 9'd0;
					y1_q <= (yx < y_q || yx >= eff_h) ? eff_h - 9'd1 : yx;
					x1_q <= (xx < x_q || xx >= eff_w) ? eff_w - 9'd1 : xx;
					corner_q <= '0;
					acc_q <= '0;
					state_q <= S_FRD;
				end
				S_FRD: begin
					count_q <= 18'((y1_q - y0_q + 9'd1) * (x1_q - x0_q + 9'd1));
					rd_pend_q <= cz;
					state_q <= S_FACC;
				end
				S_FACC: begin
					if (!rd_pend_q) begin
						case (corner_q)
							2'd0, 2'd3: acc_q <= acc_q + rd_q;
							default: acc_q <= acc_q - rd_q;
						endcase
					end
					corner_q <= corner_q + 2'd1;
					if (corner_q == 2'd3) begin
						rem_q <= '0; quo_q <= '0; bit_q <= 5'(cbb_pkg::SUM_W - 1);
						state_q <= S_DIV;
					end else begin
						state_q <= S_FRD;
					end
				end
				S_DIV: begin
					if (trial >= DW'(count_q)) begin
						rem_q <= trial - DW'(count_q);
						quo_q[bit_q] <= 1'b1;
					end else begin
						rem_q <= trial;
					end
					if (bit_q == 5'd0) state_q <= S_DIVDONE;
					else bit_q <= bit_q - 5'd1;
				end
				S_DIVDONE: begin
					outv_q[ch_q] <= quo_q[7:0];
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (3'(ch_q) + 3'd1 >= eff_c) begin
						ch_q <= '0;
						if (fx_q + 9'd1 >= eff_w) begin
							fx_q <= '0;
							fy_q <= (fy_q + 9'd1 >= eff_h) ? 9'd0 : fy_q + 9'd1;
						end else begin
							fx_q <= fx_q + 9'd1;
						end
						state_q <= S_OUT;
					end else begin
						ch_q <= ch_q + 2'd1;
						corner_q <= '0; acc_q <= '0;
						state_q <= S_FRD;
					end
				end
				S_OUT: if (res_take) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		res.out_ch0 = outv_q[0];
		res.out_ch1 = outv_q[1];
		res.out_ch2 = outv_q[2];
		res.out_ch3 = outv_q[3];
		res.frame_last = last_q;
		res.fetch_status = (job_q.op == cbb_pkg::OP_NOTREADY);
	end

	a_write_only_load: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> job_q.op == cbb_pkg::OP_LOAD) else $error("write outside load");
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_take |=> state_q != S_IDLE || restart) else $error("take not latched");
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> count_q != '0) else $error("zero divisor");

endmodule

// File: rtl/cbb_queue.sv
// Short job queue between front and back ends.
module cbb_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          flush,
	input  logic          wr,
	input  cbb_pkg::job_t wdata,
	output logic          full,
	input  logic          rd,
	output logic          valid,
	output cbb_pkg::job_t rdata
);

	cbb_pkg::job_t slot_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;

	assign full = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign rdata = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) slot_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else if (flush) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (wr && !full) wp_q <= ~wp_q;
			if (rd && valid) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr && !full} - {1'b0, rd && valid};
		end
	end

endmodule

// File: rtl/clamped_box_blur_top.sv
// Top level of the clamped box blur block.
// Load words (cmd 0) stream pixels in raster order into a per-channel summed-area table;
// for each, the back end reads and writes the table once per channel in use. Fetch words
// (cmd 1) return the clipped-window mean in raster order: per channel four table reads, a
// bit-serial divide of the 24-bit window sum and bookkeeping; the serial divider sets the
// pace, and the back end takes no new word until the result is popped. A fetch before the
// frame is fully loaded returns fetch_status set. Two words can wait between front and
// back, so input keeps flowing while the back end works until the queue fills. Writing
// width, height or channel count restarts the frame; the user must see it done with nothing
// in flight, as the block does not enforce it. Radius writes affect later fetches only.
module clamped_box_blur_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  cbb_pkg::in_word_t  word,
	output logic               empty,
	input  logic               pop,
	output cbb_pkg::out_word_t result,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [8:0]         cfg_data
);

	logic [8:0] width_q, height_q;
	logic [2:0] chan_q;
	logic [7:0] radius_q;
	logic [8:0] eff_w, eff_h;
	logic [2:0] eff_c;
	logic restart;

	assign restart = cfg_we && (cfg_index != cbb_pkg::REG_RADIUS);

	always_comb begin
		eff_w = (width_q == 9'd0) ? 9'd1 :
			({23'd0, width_q} > cbb_pkg::MAX_WIDTH) ? 9'(cbb_pkg::MAX_WIDTH) : width_q;
		eff_h = (height_q == 9'd0) ? 9'd1 :
			({23'd0, height_q} > cbb_pkg::MAX_HEIGHT) ? 9'(cbb_pkg::MAX_HEIGHT) : height_q;
		eff_c = (chan_q == 3'd0) ? 3'd1 :
			({29'd0, chan_q} > cbb_pkg::MAX_CHANNELS) ? 3'(cbb_pkg::MAX_CHANNELS) : chan_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 9'd256; height_q <= 9'd256; chan_q <= 3'd4; radius_q <= 8'd40;
		end else if (cfg_we) begin
			case (cfg_index)
				cbb_pkg::REG_WIDTH: width_q <= cfg_data;
				cbb_pkg::REG_HEIGHT: height_q <= cfg_data;
				cbb_pkg::REG_CHANNELS: chan_q <= cfg_data[2:0];
				cbb_pkg::REG_RADIUS: radius_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	cbb_pkg::job_t fjob, qjob;
	logic qvalid, qtake, take;
	assign take = push && !full;

	cbb_front u_front (
		.clk(clk), .arst_n(arst_n), .restart(restart), .eff_w(eff_w), .eff_h(eff_h),
		.word(word), .take(take), .job(fjob)
	);

	cbb_queue u_queue (
		.clk(clk), .arst_n(arst_n), .flush(restart), .wr(push), .wdata(fjob), .full(full),
		.rd(qtake), .valid(qvalid), .rdata(qjob)
	);

	logic res_valid;
	cbb_back u_back (
		.clk(clk), .arst_n(arst_n), .restart(restart), .eff_w(eff_w), .eff_h(eff_h),
		.eff_c(eff_c), .radius(radius_q), .job_valid(qvalid), .job(qjob), .job_take(qtake),
		.res_valid(res_valid), .res(result), .res_take(pop)
	);

	assign empty = !res_valid;

endmodule

// File: tb/tb.sv
// Testbench for clamped_box_blur_top: randomized frames checked against a summed-area predictor.
`timescale 1ns / 1ps
module tb;

	logic clk, arst_n;
	logic push, full, empty, pop;
	cbb_pkg::in_word_t word;
	cbb_pkg::out_word_t result;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [8:0] cfg_data;

	clamped_box_blur_top uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .word(word),
		.empty(empty), .pop(pop), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	cbb_pkg::in_word_t pending_words[$];
	cbb_pkg::out_word_t blur_expect[$];
	int errors = 0;
	int cycles = 0;
	int issued = 0;
	bit steady = 0;
	int send_gap = 0;
	int recv_gap = 0;

	// predictor state
	bit [23:0] sat_mem [0:262143];
	bit [23:0] row_acc [4];
	int load_x, load_y, fetch_x, fetch_y;
	bit frame_done;
	bit [8:0] img_w_reg, img_h_reg;
	bit [2:0] chan_reg;
	bit [7:0] radius_reg;

	function automatic int clip_size(int v, int hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int sat_addr(int r, int c, int chn);
		return (r * 256 + c) * 4 + chn;
	endfunction

	function automatic int sat_rd(int r, int c, int chn);
		if (r < 0 || c < 0) return 0;
		return sat_mem[sat_addr(r, c, chn)];
	endfunction

	function automatic void clear_frame();
		for (int i = 0; i < 4; i++) row_acc[i] = '0;
		load_x = 0; load_y = 0; fetch_x = 0; fetch_y = 0;
		frame_done = 0;
	endfunction

	function automatic void blur_predict(cbb_pkg::in_word_t w);
		int iw, ih, nc, y0, y1, x0, x1, cnt, s;
		bit [7:0] v [4];
		bit [7:0] res [4];
		cbb_pkg::out_word_t o;
		iw = clip_size(img_w_reg, 256);
		ih = clip_size(img_h_reg, 256);
		nc = clip_size(chan_reg, 4);
		v[0] = w.in_ch0; v[1] = w.in_ch1; v[2] = w.in_ch2; v[3] = w.in_ch3;
		res[0] = 0; res[1] = 0; res[2] = 0; res[3] = 0;
		o = '0;
		if (w.cmd == cbb_pkg::CMD_LOAD) begin
			if (frame_done) clear_frame();
			for (int c = 0; c < nc; c++) begin
				row_acc[c] = row_acc[c] + v[c];
				sat_mem[sat_addr(load_y, load_x, c)] = row_acc[c] +
					((load_y > 0) ? sat_mem[sat_addr(load_y - 1, load_x, c)] : 24'd0);
			end
			load_x++;
			if (load_x >= iw) begin
				load_x = 0;
				for (int i = 0; i < 4; i++) row_acc[i] = '0;
				load_y++;
				if (load_y >= ih) frame_done = 1;
			end
			return;
		end
		if (!frame_done) begin
			o.fetch_status = 1'b1;
			blur_expect.push_back(o);
			return;
		end
		y0 = fetch_y - radius_reg; y1 = fetch_y + radius_reg;
		x0 = fetch_x - radius_reg; x1 = fetch_x + radius_reg;
		if (y0 < 0) y0 = 0;
		if (x0 < 0) x0 = 0;
		if (y1 > ih - 1) y1 = ih - 1;
		if (x1 > iw - 1) x1 = iw - 1;
		cnt = (y1 - y0 + 1) * (x1 - x0 + 1);
		for (int c = 0; c < nc; c++) begin
			s = sat_rd(y1, x1, c) - sat_rd(y0 - 1, x1, c) - sat_rd(y1, x0 - 1, c)
				+ sat_rd(y0 - 1, x0 - 1, c);
			res[c] = 8'(s / cnt);
		end
		o.out_ch0 = res[0]; o.out_ch1 = res[1]; o.out_ch2 = res[2]; o.out_ch3 = res[3];
		fetch_x++;
		if (fetch_x >= iw) begin
			fetch_x = 0;
			fetch_y++;
			if (fetch_y >= ih) begin
				fetch_y = 0;
				o.frame_last = 1'b1;
			end
		end
		blur_expect.push_back(o);
	endfunction

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// input side
	always @(posedge clk or negedge arst_n) begin
		int g;
		if (!arst_n) begin
			push <= 0;
			word <= '0;
		end else begin
			if (push && !full) begin
				blur_predict(word);
				g = steady ? 0 : $urandom_range(0, 15);
				if (g == 0 && pending_words.size() > 0) begin
					word <= pending_words.pop_front();
				end else begin
					push <= 0;
					send_gap <= g;
				end
			end else if (!push) begin
				if (send_gap > 0) send_gap <= send_gap - 1;
				else if (pending_words.size() > 0) begin
					word <= pending_words.pop_front();
					push <= 1;
				end
			end
		end
	end

	// result side
	always @(posedge clk or negedge arst_n) begin
		cbb_pkg::out_word_t e;
		int g;
		if (!arst_n) begin
			pop <= 0;
		end else begin
			cycles++;
			if (cycles > 3000000) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
			if (pop && !empty) begin
				if (blur_expect.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected word %h", result);
				end else begin
					e = blur_expect.pop_front();
					if (e.out_ch0 !== result.out_ch0 || e.out_ch1 !== result.out_ch1 ||
					    e.out_ch2 !== result.out_ch2 || e.out_ch3 !== result.out_ch3 ||
					    e.frame_last !== result.frame_last ||
					    e.fetch_status !== result.fetch_status) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %h got %h", e, result);
					end
				end
				g = steady ? 0 : $urandom_range(0, 15);
				if (g != 0) begin
					pop <= 0;
					recv_gap <= g;
				end
			end else if (!pop) begin
				if (recv_gap > 0) recv_gap <= recv_gap - 1;
				else pop <= 1;
			end
		end
	end

	task automatic settle();
		while (pending_words.size() > 0 || push || blur_expect.size() > 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [8:0] val);
		@(posedge clk);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
		case (idx)
			cbb_pkg::REG_WIDTH: begin img_w_reg = val; clear_frame(); end
			cbb_pkg::REG_HEIGHT: begin img_h_reg = val; clear_frame(); end
			cbb_pkg::REG_CHANNELS: begin chan_reg = val[2:0]; clear_frame(); end
			cbb_pkg::REG_RADIUS: radius_reg = val[7:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic setup(int w, int h, int c, int r);
		settle();
		reg_write(cbb_pkg::REG_WIDTH, 9'(w));
		reg_write(cbb_pkg::REG_HEIGHT, 9'(h));
		reg_write(cbb_pkg::REG_CHANNELS, 9'(c));
		reg_write(cbb_pkg::REG_RADIUS, 9'(r));
	endtask

	task automatic add_word(logic cmd, logic [7:0] a, logic [7:0] b, logic [7:0] c,
	                        logic [7:0] d);
		cbb_pkg::in_word_t w;
		w.cmd = cmd; w.in_ch0 = a; w.in_ch1 = b; w.in_ch2 = c; w.in_ch3 = d;
		pending_words.push_back(w);
		issued++;
	endtask

	task automatic add_rand(logic cmd);
		add_word(cmd, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	initial begin
		int w, h, c, r, n, k;
		arst_n = 0;
		cfg_we = 0; cfg_index = '0; cfg_data = '0;
		img_w_reg = 9'd256; img_h_reg = 9'd256; chan_reg = 3'd4; radius_reg = 8'd40;
		clear_frame();
		repeat (8) @(posedge clk);
		arst_n <= 1;

		// not ready under reset sizes
		add_word(cbb_pkg::CMD_FETCH, 0, 0, 0, 0);
		setup(3, 2, 4, 0);
		add_word(cbb_pkg::CMD_LOAD, 8'h00, 8'hff, 8'h00, 8'hff);
		add_word(cbb_pkg::CMD_FETCH, 0, 0, 0, 0);
		add_word(cbb_pkg::CMD_LOAD, 8'hff, 8'h00, 8'hff, 8'h00);
		add_word(cbb_pkg::CMD_LOAD, 8'hff, 8'hff, 8'hff, 8'hff);
		add_word(cbb_pkg::CMD_LOAD, 8'h00, 8'h00, 8'h00, 8'h00);
		add_word(cbb_pkg::CMD_LOAD, 8'haa, 8'h55, 8'h01, 8'h80);
		add_word(cbb_pkg::CMD_LOAD, 8'h55, 8'haa, 8'hfe, 8'h7f);
		repeat (7) add_word(cbb_pkg::CMD_FETCH, 0, 0, 0, 0);
		add_word(cbb_pkg::CMD_LOAD, 8'h12, 8'h34, 8'h56, 8'h78);
		add_word(cbb_pkg::CMD_FETCH, 0, 0, 0, 0);
		// zero sizes act as one, widest radius
		setup(0, 0, 0, 255);
		add_word(cbb_pkg::CMD_LOAD, 8'hff, 8'hff, 8'hff, 8'hff);
		repeat (2) add_word(cbb_pkg::CMD_FETCH, 0, 0, 0, 0);

		k = 0;
		while (issued < 880) begin
			k++;
			if (k % 9 == 4) begin
				w = $urandom_range(256, 511); h = $urandom_range(0, 1);
			end else if (k % 9 == 8) begin
				w = $urandom_range(0, 1); h = $urandom_range(256, 511);
			end else begin
				w = $urandom_range(0, 7); h = $urandom_range(0, 7);
			end
			c = $urandom_range(0, 7);
			r = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 255);
			setup(w, h, c, r);
			steady = ($urandom_range(0, 3) == 0);
			n = clip_size(w, 256) * clip_size(h, 256);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 7) == 0) add_rand(cbb_pkg::CMD_FETCH);
				add_rand(cbb_pkg::CMD_LOAD);
			end
			n = (n > 40) ? $urandom_range(1, 6) : $urandom_range(1, 2 * n + 1);
			repeat (n) add_rand(cbb_pkg::CMD_FETCH);
			if ($urandom_range(0, 2) == 0) begin
				repeat ($urandom_range(1, 3)) add_rand(cbb_pkg::CMD_LOAD);
				add_rand(cbb_pkg::CMD_FETCH);
			end
		end
		settle();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
